### sv/aps_pkg.sv
package aps_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PLAY  = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic REG_STEP_COUNT = 1'b0;
    localparam logic REG_LOOP_COUNT = 1'b1;

    localparam int unsigned PADDR_W = 3;

    typedef struct packed {
        logic        status;
        logic        apply_valid;
        logic        apply_on;
        logic [31:0] apply_payload;
        logic [3:0]  applied_step;
    } result_t;

endpackage

### sv/aps_step_mem.sv
module aps_step_mem #(
    parameter int unsigned MAX_STEPS = 16,
    parameter int unsigned PW        = 32
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(MAX_STEPS)-1:0]  waddr,
    input  logic [15:0]                   wms,
    input  logic [PW-1:0]                 wpay,
    input  logic [$clog2(MAX_STEPS)-1:0]  raddr,
    output logic [15:0]                   rd_ms,
    output logic [PW-1:0]                 rd_pay,
    output logic [15:0]                   e0_ms,
    output logic [PW-1:0]                 e0_pay
);

    localparam int unsigned IDX_W = $clog2(MAX_STEPS);
    localparam int unsigned EW    = 16 + PW;

    logic [EW-1:0] mem_reg [MAX_STEPS];
    logic [EW-1:0] rd_reg;
    logic [EW-1:0] e0_reg;
    logic [EW-1:0] wentry;

    assign wentry = {wms, wpay};

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wentry;
        end
        if (we && (waddr == raddr)) begin
            rd_reg <= wentry;
        end else begin
            rd_reg <= mem_reg[raddr];
        end
        if (we && (waddr == IDX_W'(0))) begin
            e0_reg <= wentry;
        end
    end

    assign rd_ms  = rd_reg[EW-1:PW];
    assign rd_pay = rd_reg[PW-1:0];
    assign e0_ms  = e0_reg[EW-1:PW];
    assign e0_pay = e0_reg[PW-1:0];

endmodule

### sv/aps_ctrl.sv
module aps_ctrl #(
    parameter int unsigned MAX_STEPS = 16,
    parameter int unsigned PW        = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [1:0]                    op,
    input  logic                          force_req,
    input  logic [3:0]                    step_addr,
    input  logic [15:0]                   step_ms,
    input  logic [31:0]                   step_payload,
    input  logic [4:0]                    step_count,
    input  logic [7:0]                    repeat_limit,
    input  logic [15:0]                   rd_ms,
    input  logic [PW-1:0]                 rd_pay,
    input  logic [15:0]                   e0_ms,
    input  logic [PW-1:0]                 e0_pay,
    output logic                          we,
    output logic [$clog2(MAX_STEPS)-1:0]  waddr,
    output logic [15:0]                   wms,
    output logic [PW-1:0]                 wpay,
    output logic [$clog2(MAX_STEPS)-1:0]  raddr,
    output aps_pkg::result_t              res
);

    localparam int unsigned IDX_W = $clog2(MAX_STEPS);
    localparam int unsigned CW    = $clog2(MAX_STEPS + 1);
    localparam int unsigned CMP_W = (CW > 5) ? CW : 5;
    localparam int unsigned AW    = (CW > 4) ? CW : 4;

    logic [IDX_W-1:0] step_index_reg, step_index_next;
    logic [7:0]       loop_index_reg, loop_index_next;
    logic             pattern_active_reg, pattern_active_next;
    logic             timer_running_reg, timer_running_next;
    logic [15:0]      ticks_left_reg, ticks_left_next;

    logic             adv;
    logic             adv_active;
    logic [IDX_W-1:0] adv_idx;
    logic [7:0]       adv_loop;
    logic [15:0]      adv_ms;
    logic [PW-1:0]    adv_pay;
    logic [CMP_W-1:0] eff;
    logic [CMP_W-1:0] sc_ext;
    logic [CMP_W-1:0] idx_inc;
    logic             addr_ok;

    assign sc_ext  = CMP_W'(step_count);
    assign addr_ok = AW'(step_addr) < AW'(MAX_STEPS);
    assign waddr   = IDX_W'(step_addr);
    assign wms     = step_ms;
    assign wpay    = PW'(step_payload);
    assign raddr   = step_index_next;
    assign idx_inc = CMP_W'(adv_idx) + CMP_W'(1);

    always_comb begin
        if (sc_ext == CMP_W'(0)) begin
            eff = CMP_W'(1);
        end else if (sc_ext > CMP_W'(MAX_STEPS)) begin
            eff = CMP_W'(MAX_STEPS);
        end else begin
            eff = sc_ext;
        end
    end

    always_comb begin
        step_index_next     = step_index_reg;
        loop_index_next     = loop_index_reg;
        pattern_active_next = pattern_active_reg;
        timer_running_next  = timer_running_reg;
        ticks_left_next     = ticks_left_reg;
        res                 = '0;
        we                  = 1'b0;
        adv                 = 1'b0;
        adv_active          = pattern_active_reg;
        adv_idx             = step_index_reg;
        adv_loop            = loop_index_reg;
        adv_ms              = rd_ms;
        adv_pay             = rd_pay;

        if (accept) begin
            unique case (op)
                aps_pkg::OP_TICK: begin
                    if (timer_running_reg) begin
                        if (ticks_left_reg <= 16'd1) begin
                            adv = 1'b1;
                        end else begin
                            ticks_left_next = ticks_left_reg - 16'd1;
                        end
                    end
                end
                aps_pkg::OP_PLAY: begin
                    if (pattern_active_reg && !force_req) begin
                        res.status = 1'b1;
                    end else begin
                        adv        = 1'b1;
                        adv_active = 1'b1;
                        adv_idx    = '0;
                        adv_loop   = '0;
                        adv_ms     = e0_ms;
                        adv_pay    = e0_pay;
                    end
                end
                aps_pkg::OP_STOP: begin
                    pattern_active_next = 1'b0;
                end
                aps_pkg::OP_WRITE: begin
                    we = addr_ok;
                end
                default: begin
                end
            endcase
        end

        if (adv) begin
            res.apply_valid = 1'b1;
            if (adv_active && ((repeat_limit == 8'd0) || (adv_loop < repeat_limit))) begin
                res.apply_on        = 1'b1;
                res.apply_payload   = 32'(adv_pay);
                res.applied_step    = 4'(adv_idx);
                ticks_left_next     = adv_ms;
                timer_running_next  = 1'b1;
                pattern_active_next = 1'b1;
                if (idx_inc >= eff) begin
                    step_index_next = '0;
                    loop_index_next = adv_loop + 8'd1;
                end else begin
                    step_index_next = IDX_W'(idx_inc);
                    loop_index_next = adv_loop;
                end
            end else begin
                pattern_active_next = 1'b0;
                timer_running_next  = 1'b0;
                ticks_left_next     = 16'd0;
                step_index_next     = adv_idx;
                loop_index_next     = adv_loop;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_index_reg     <= '0;
            loop_index_reg     <= '0;
            pattern_active_reg <= 1'b0;
            timer_running_reg  <= 1'b0;
            ticks_left_reg     <= '0;
        end else begin
            step_index_reg     <= step_index_next;
            loop_index_reg     <= loop_index_next;
            pattern_active_reg <= pattern_active_next;
            timer_running_reg  <= timer_running_next;
            ticks_left_reg     <= ticks_left_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_timer_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !timer_running_reg |-> (ticks_left_reg == 16'd0))
        else $error("ticks pending with timer stopped");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(step_index_reg) < CW'(MAX_STEPS))
        else $error("step index beyond table");

    a_on_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res.apply_on) |-> res.apply_valid)
        else $error("drive on without command");

    a_busy_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res.status) |=> ($stable(step_index_reg) && $stable(ticks_left_reg)))
        else $error("refused play changed state");
`endif

endmodule

### sv/aps_out_buf.sv
module aps_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  aps_pkg::result_t din,
    output logic             full,
    output logic             m_valid,
    input  logic             m_ready,
    output aps_pkg::result_t dout
);

    aps_pkg::result_t buf_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             pop;

    assign full    = (cnt_reg == 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign dout    = buf_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### sv/alert_pattern_sequencer_top.sv
// Alert pattern sequencer: plays a stored table of steps (duration in ticks plus drive
// payload) on one alert channel. Every input word (tick, play, stop or step write) yields
// exactly one result word. Words are taken at one per clock: the whole update goes
// straight from the accepted word into the sequencer state and a two-deep result
// buffer, so input stalls only when both result slots are held by the sink. The step
// table is a memory with one read port prefetching the current step plus a copy of step
// 0 for play; it needs no clearing after reset, and a step never written must not be
// played. The step count (offset 0x0) and the repeat limit (offset 0x4) are set over
// the APB port.
module alert_pattern_sequencer_top #(
    parameter int unsigned MAX_STEPS    = 16,
    parameter int unsigned PAYLOAD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aps_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic                          s_force_req,
    input  logic [3:0]                    s_step_addr,
    input  logic [15:0]                   s_step_ms,
    input  logic [31:0]                   s_step_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic                          m_apply_valid,
    output logic                          m_apply_on,
    output logic [31:0]                   m_apply_payload,
    output logic [3:0]                    m_applied_step
);

    localparam int unsigned IDX_W = $clog2(MAX_STEPS);
    localparam int unsigned PW    = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

    logic [4:0]       step_count_reg;
    logic [7:0]       repeat_limit_reg;
    logic             cfg_we;
    logic             accept;
    logic             full;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [15:0]      wms;
    logic [PW-1:0]    wpay;
    logic [15:0]      rd_ms;
    logic [PW-1:0]    rd_pay;
    logic [15:0]      e0_ms;
    logic [PW-1:0]    e0_pay;
    aps_pkg::result_t res;
    aps_pkg::result_t dout;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg   <= 5'd1;
            repeat_limit_reg <= 8'd0;
        end else if (cfg_we) begin
            unique case (paddr[2])
                aps_pkg::REG_STEP_COUNT: step_count_reg   <= pwdata[4:0];
                aps_pkg::REG_LOOP_COUNT: repeat_limit_reg <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            aps_pkg::REG_STEP_COUNT: prdata = {27'd0, step_count_reg};
            aps_pkg::REG_LOOP_COUNT: prdata = {24'd0, repeat_limit_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    aps_step_mem #(
        .MAX_STEPS (MAX_STEPS),
        .PW        (PW)
    ) u_mem (
        .aclk   (aclk),
        .we     (we),
        .waddr  (waddr),
        .wms    (wms),
        .wpay   (wpay),
        .raddr  (raddr),
        .rd_ms  (rd_ms),
        .rd_pay (rd_pay),
        .e0_ms  (e0_ms),
        .e0_pay (e0_pay)
    );

    aps_ctrl #(
        .MAX_STEPS (MAX_STEPS),
        .PW        (PW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .op           (s_op),
        .force_req    (s_force_req),
        .step_addr    (s_step_addr),
        .step_ms      (s_step_ms),
        .step_payload (s_step_payload),
        .step_count   (step_count_reg),
        .repeat_limit (repeat_limit_reg),
        .rd_ms        (rd_ms),
        .rd_pay       (rd_pay),
        .e0_ms        (e0_ms),
        .e0_pay       (e0_pay),
        .we           (we),
        .waddr        (waddr),
        .wms          (wms),
        .wpay         (wpay),
        .raddr        (raddr),
        .res          (res)
    );

    aps_out_buf u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .din     (res),
        .full    (full),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dout    (dout)
    );

    assign m_status        = dout.status;
    assign m_apply_valid   = dout.apply_valid;
    assign m_apply_on      = dout.apply_on;
    assign m_apply_payload = dout.apply_payload;
    assign m_applied_step  = dout.applied_step;

endmodule
